// ===== hw/rtl/frs_pkg.sv =====
`default_nettype none

package frs_pkg;

	// Default working width of the running sum.
	localparam int VALUE_WIDTH_DEF = 32;

	// Width of the fraction fields on the ports.
	localparam int FIELD_WIDTH = 32;

	// Multiplier digit: bits of the second operand consumed per cycle.
	localparam int MUL_DIGIT = 16;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_WRAP      = 2'd1,
		STAT_NO_REDUCE = 2'd2
	} status_t;

	// Operand selection for the shared divider.
	typedef enum logic [1:0] {
		DIV_EUCLID = 2'd0,
		DIV_QUOT_N = 2'd1,
		DIV_QUOT_D = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     load_acc;
		logic     mul_start;
		logic     acc_update;
		logic     gcd_load;
		logic     div_start;
		div_sel_t div_sel;
		logic     gcd_write;
		logic     save_qn;
		logic     save_qd;
		logic     emit;
		logic     emit_raw;
	} frs_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic any_zero;
		logic g_zero;
		logic euclid_stall;
	} frs_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/frs_mul.sv =====
`default_nettype none

module frs_mul #(
	parameter int VALUE_WIDTH = frs_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [VALUE_WIDTH-1:0] a,
	input  wire logic [VALUE_WIDTH-1:0] b,
	output logic                        done,
	output logic [VALUE_WIDTH-1:0]      prod,
	output logic                        ovf
);

	localparam int W    = VALUE_WIDTH;
	localparam int D    = frs_pkg::MUL_DIGIT;
	localparam int NDIG = (W + D - 1) / D;
	localparam int LW   = NDIG * D;
	localparam int PW   = W + D;
	localparam int CW   = $clog2(NDIG + 1);
	localparam logic [CW-1:0] LAST_CNT = CW'(NDIG);

	logic [W-1:0]    ma_q;
	logic [LW-1:0]   mb_q;
	logic [W-1:0]    hi_q;
	logic [LW-1:0]   lo_q;
	logic            neg_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [W-1:0]    prod_q;
	logic            ovf_q;

	logic [W-1:0]    a_mag;
	logic [W-1:0]    b_mag;
	logic [PW-1:0]   pp;
	logic [PW-1:0]   sum;
	logic [LW+D-1:0] lo_shift;
	logic [W+LW-1:0] m_full;
	logic [LW:0]     m_upper;
	logic [W-1:0]    m_lo;
	logic            m_big;
	logic            m_half;

	assign a_mag = a[W-1] ? (~a + 1'b1) : a;
	assign b_mag = b[W-1] ? (~b + 1'b1) : b;

	assign pp       = ma_q * mb_q[D-1:0];
	assign sum      = PW'(hi_q) + pp;
	assign lo_shift = {sum[D-1:0], lo_q};

	assign m_full  = {hi_q, lo_q};
	assign m_upper = m_full[W+LW-1:W-1];
	assign m_lo    = m_full[W-1:0];
	assign m_big   = |m_upper;
	// A negative product may reach exactly the most negative value.
	assign m_half  = (m_upper == (LW+1)'(1)) && (m_full[W-2:0] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST_CNT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= a_mag;
			mb_q  <= LW'(b_mag);
			hi_q  <= '0;
			lo_q  <= '0;
			neg_q <= a[W-1] ^ b[W-1];
		end else if (busy_q) begin
			if (cnt_q == LAST_CNT) begin
				prod_q <= neg_q ? (~m_lo + 1'b1) : m_lo;
				ovf_q  <= m_big && !(neg_q && m_half);
			end else begin
				hi_q <= sum[PW-1:D];
				lo_q <= lo_shift[LW+D-1:D];
				mb_q <= mb_q >> D;
			end
		end
	end

	assign done = done_q;
	assign prod = prod_q;
	assign ovf  = ovf_q;

	a_mul_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("multiplier started while busy");

endmodule

`default_nettype wire

// ===== hw/rtl/frs_div.sv =====
`default_nettype none

module frs_div #(
	parameter int VALUE_WIDTH = frs_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [VALUE_WIDTH-1:0] dvd,
	input  wire logic [VALUE_WIDTH-1:0] dvs,
	output logic                        done,
	output logic [VALUE_WIDTH-1:0]      quot,
	output logic [VALUE_WIDTH-1:0]      rem
);

	localparam int W  = VALUE_WIDTH;
	localparam int CW = $clog2(W + 1);
	localparam logic [CW-1:0] LAST_CNT = CW'(W);

	logic [W-1:0]  dv_q;
	logic [W-1:0]  qt_q;
	logic [W-1:0]  rm_q;
	logic          negq_q;
	logic          negr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W-1:0]  quot_q;
	logic [W-1:0]  rem_q;

	logic [W-1:0]  dvd_mag;
	logic [W-1:0]  dvs_mag;
	logic [W-1:0]  shifted;
	logic [W:0]    diff;

	assign dvd_mag = dvd[W-1] ? (~dvd + 1'b1) : dvd;
	assign dvs_mag = dvs[W-1] ? (~dvs + 1'b1) : dvs;

	// The partial remainder stays below the divisor magnitude, which is at
	// most half the range, so one shifted bit still fits in W bits.
	assign shifted = {rm_q[W-2:0], qt_q[W-1]};
	assign diff    = {1'b0, shifted} - {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST_CNT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dv_q   <= dvs_mag;
			qt_q   <= dvd_mag;
			rm_q   <= '0;
			negq_q <= dvd[W-1] ^ dvs[W-1];
			negr_q <= dvd[W-1];
		end else if (busy_q) begin
			if (cnt_q == LAST_CNT) begin
				quot_q <= negq_q ? (~qt_q + 1'b1) : qt_q;
				rem_q  <= negr_q ? (~rm_q + 1'b1) : rm_q;
			end else begin
				rm_q <= diff[W] ? shifted : diff[W-1:0];
				qt_q <= {qt_q[W-2:0], ~diff[W]};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

	a_div_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

endmodule

`default_nettype wire

// ===== hw/rtl/frs_datapath.sv =====
`default_nettype none

module frs_datapath #(
	parameter int VALUE_WIDTH = frs_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire frs_pkg::frs_cmd_t                      cmd,
	output frs_pkg::frs_stat_t                          stat,
	input  wire logic signed [frs_pkg::FIELD_WIDTH-1:0] numerator,
	input  wire logic signed [frs_pkg::FIELD_WIDTH-1:0] denominator,
	output logic signed [frs_pkg::FIELD_WIDTH-1:0]      sum_numerator,
	output logic signed [frs_pkg::FIELD_WIDTH-1:0]      sum_denominator,
	output logic [1:0]                                  status
);

	localparam int W  = VALUE_WIDTH;
	localparam int FW = frs_pkg::FIELD_WIDTH;

	logic signed [W-1:0] in_n_w;
	logic signed [W-1:0] in_d_w;

	logic [W-1:0] acc_n_q;
	logic [W-1:0] acc_d_q;
	logic         wrap_q;
	logic [W-1:0] ga_q;
	logic [W-1:0] gb_q;
	logic         wa_q;
	logic [W-1:0] qn_q;
	logic [W-1:0] qd_q;
	logic [FW-1:0] out_n_q;
	logic [FW-1:0] out_d_q;
	frs_pkg::status_t out_st_q;

	logic [W-1:0] p_nd;
	logic [W-1:0] p_dn;
	logic [W-1:0] p_dd;
	logic         ovf_nd;
	logic         ovf_dn;
	logic         ovf_dd;
	logic         done_nd;
	logic         done_dn;
	logic         done_dd;
	logic [W-1:0] nn;
	logic         add_ovf;

	logic [W-1:0] g;
	logic         a_side;
	logic [W-1:0] div_dvd;
	logic [W-1:0] div_dvs;
	logic         div_done;
	logic [W-1:0] div_q;
	logic [W-1:0] div_r;
	logic [W-1:0] emit_n;
	logic [W-1:0] emit_d;

	// Inputs are sign-extended or truncated to the working width.
	assign in_n_w = W'(numerator);
	assign in_d_w = W'(denominator);

	frs_mul #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul_nd (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.a     (acc_n_q),
		.b     (in_d_w),
		.done  (done_nd),
		.prod  (p_nd),
		.ovf   (ovf_nd)
	);

	frs_mul #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul_dn (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.a     (acc_d_q),
		.b     (in_n_w),
		.done  (done_dn),
		.prod  (p_dn),
		.ovf   (ovf_dn)
	);

	frs_mul #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul_dd (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.a     (acc_d_q),
		.b     (in_d_w),
		.done  (done_dd),
		.prod  (p_dd),
		.ovf   (ovf_dd)
	);

	assign nn      = p_nd + p_dn;
	assign add_ovf = (p_nd[W-1] == p_dn[W-1]) && (nn[W-1] != p_nd[W-1]);

	// Once the Euclid loop has ended one side is zero, so the other is the gcd.
	assign g      = ga_q | gb_q;
	assign a_side = $signed(gb_q) < $signed(ga_q);

	always_comb begin
		case (cmd.div_sel)
			frs_pkg::DIV_EUCLID: begin
				div_dvd = a_side ? ga_q : gb_q;
				div_dvs = a_side ? gb_q : ga_q;
			end
			frs_pkg::DIV_QUOT_N: begin
				div_dvd = acc_n_q;
				div_dvs = g;
			end
			frs_pkg::DIV_QUOT_D: begin
				div_dvd = acc_d_q;
				div_dvs = g;
			end
			default: begin
				div_dvd = acc_n_q;
				div_dvs = g;
			end
		endcase
	end

	frs_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.dvd   (div_dvd),
		.dvs   (div_dvs),
		.done  (div_done),
		.quot  (div_q),
		.rem   (div_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_n_q <= '0;
			acc_d_q <= W'(1);
			wrap_q  <= 1'b0;
		end else if (cmd.load_acc) begin
			acc_n_q <= in_n_w;
			acc_d_q <= in_d_w;
			wrap_q  <= 1'b0;
		end else if (cmd.acc_update) begin
			acc_n_q <= nn;
			acc_d_q <= p_dd;
			wrap_q  <= wrap_q | ovf_nd | ovf_dn | ovf_dd | add_ovf;
		end
	end

	assign emit_n = cmd.emit_raw ? acc_n_q : qn_q;
	assign emit_d = cmd.emit_raw ? acc_d_q : qd_q;

	always_ff @(posedge clk) begin
		if (cmd.gcd_load) begin
			ga_q <= acc_n_q;
			gb_q <= acc_d_q;
		end else if (cmd.gcd_write) begin
			if (wa_q) begin
				ga_q <= div_r;
			end else begin
				gb_q <= div_r;
			end
		end
		if (cmd.div_start && (cmd.div_sel == frs_pkg::DIV_EUCLID)) begin
			wa_q <= a_side;
		end
		if (cmd.save_qn) begin
			qn_q <= div_q;
		end
		if (cmd.save_qd) begin
			qd_q <= div_q;
		end
		if (cmd.emit) begin
			out_n_q <= FW'($signed(emit_n));
			out_d_q <= FW'($signed(emit_d));
			if (cmd.emit_raw) begin
				out_st_q <= frs_pkg::STAT_NO_REDUCE;
			end else if (wrap_q) begin
				out_st_q <= frs_pkg::STAT_WRAP;
			end else begin
				out_st_q <= frs_pkg::STAT_OK;
			end
		end
	end

	always_comb begin
		stat.mul_done     = done_nd & done_dn & done_dd;
		stat.div_done     = div_done;
		stat.any_zero     = (ga_q == '0) || (gb_q == '0);
		stat.g_zero       = (g == '0);
		// A remainder equal to its dividend would repeat forever.
		stat.euclid_stall = (div_r == (wa_q ? ga_q : gb_q));
	end

	assign sum_numerator   = out_n_q;
	assign sum_denominator = out_d_q;
	assign status          = out_st_q;

endmodule

`default_nettype wire

// ===== hw/rtl/frs_ctrl.sv =====
`default_nettype none

module frs_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               last_item,
	output logic                    in_stall,
	input  wire logic               out_stall,
	output logic                    out_valid,
	output frs_pkg::frs_cmd_t       cmd,
	input  wire frs_pkg::frs_stat_t stat
);

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_MUL      = 8'b0000_0010,
		ST_GCD_LOAD = 8'b0000_0100,
		ST_GCD_TEST = 8'b0000_1000,
		ST_GCD_WAIT = 8'b0001_0000,
		ST_QN_WAIT  = 8'b0010_0000,
		ST_QD_WAIT  = 8'b0100_0000,
		ST_EMIT     = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   set_started_q;
	logic   set_started_d;
	logic   last_q;
	logic   last_d;
	logic   noreduce_q;
	logic   noreduce_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d       = state_q;
		set_started_d = set_started_q;
		last_d        = last_q;
		noreduce_d    = noreduce_q;
		cmd           = '0;
		cmd.div_sel   = frs_pkg::DIV_EUCLID;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					last_d = last_item;
					if (set_started_q) begin
						cmd.mul_start = 1'b1;
						state_d       = ST_MUL;
					end else begin
						cmd.load_acc  = 1'b1;
						set_started_d = 1'b1;
						if (last_item) begin
							state_d = ST_GCD_LOAD;
						end
					end
				end
			end
			ST_MUL: begin
				if (stat.mul_done) begin
					cmd.acc_update = 1'b1;
					state_d        = last_q ? ST_GCD_LOAD : ST_IDLE;
				end
			end
			ST_GCD_LOAD: begin
				cmd.gcd_load = 1'b1;
				noreduce_d   = 1'b0;
				state_d      = ST_GCD_TEST;
			end
			ST_GCD_TEST: begin
				if (stat.any_zero) begin
					if (stat.g_zero) begin
						noreduce_d = 1'b1;
						state_d    = ST_EMIT;
					end else begin
						cmd.div_start = 1'b1;
						cmd.div_sel   = frs_pkg::DIV_QUOT_N;
						state_d       = ST_QN_WAIT;
					end
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_GCD_WAIT;
				end
			end
			ST_GCD_WAIT: begin
				if (stat.div_done) begin
					if (stat.euclid_stall) begin
						noreduce_d = 1'b1;
						state_d    = ST_EMIT;
					end else begin
						cmd.gcd_write = 1'b1;
						state_d       = ST_GCD_TEST;
					end
				end
			end
			ST_QN_WAIT: begin
				if (stat.div_done) begin
					cmd.save_qn   = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = frs_pkg::DIV_QUOT_D;
					state_d       = ST_QD_WAIT;
				end
			end
			ST_QD_WAIT: begin
				if (stat.div_done) begin
					cmd.save_qd = 1'b1;
					state_d     = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_raw  = noreduce_q;
					set_started_d = 1'b0;
					noreduce_d    = 1'b0;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			set_started_q <= 1'b0;
			last_q        <= 1'b0;
			noreduce_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			set_started_q <= set_started_d;
			last_q        <= last_d;
			noreduce_q    <= noreduce_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	a_div_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == ST_GCD_WAIT || state_q == ST_QN_WAIT ||
			state_q == ST_QD_WAIT))
		else $error("divider finished while no division was awaited");

	a_mul_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		stat.mul_done |-> (state_q == ST_MUL))
		else $error("multipliers finished outside the accumulate step");

	a_mul_needs_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> set_started_q)
		else $error("accumulating into a sum that was never loaded");

endmodule

`default_nettype wire

// ===== hw/rtl/fraction_sum_reduce.sv =====
// Adds up a set of signed fractions and returns the sum reduced by its gcd.
// The first word of a set loads the sum; each later word n/d turns sn/sd into
// (sn*d + sd*n)/(sd*d), wrapping at VALUE_WIDTH bits, and any wrap sets status
// 1. The word with last_item set ends the set and produces one result word;
// status 2 means the summed numerator and denominator were both zero or
// Euclid's loop could not make progress, and the sum is then returned
// unreduced. An accumulating word goes through the three parallel
// multipliers, which consume 16 bits of one operand per cycle. A last word
// then runs every Euclid remainder step and both final quotients through one
// shared divider that retires one bit per cycle, and waits out any output
// stall. A finished result waits in an output register, so the next word can
// be taken while it is still stalled.
`default_nettype none

module fraction_sum_reduce #(
	parameter int VALUE_WIDTH = frs_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [frs_pkg::FIELD_WIDTH-1:0] numerator,
	input  wire logic signed [frs_pkg::FIELD_WIDTH-1:0] denominator,
	input  wire logic                                   last_item,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [frs_pkg::FIELD_WIDTH-1:0]      sum_numerator,
	output logic signed [frs_pkg::FIELD_WIDTH-1:0]      sum_denominator,
	output logic [1:0]                                  status
);

	frs_pkg::frs_cmd_t  cmd;
	frs_pkg::frs_stat_t stat;

	frs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last_item(last_item),
		.in_stall (in_stall),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.cmd      (cmd),
		.stat     (stat)
	);

	frs_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.numerator      (numerator),
		.denominator    (denominator),
		.sum_numerator  (sum_numerator),
		.sum_denominator(sum_denominator),
		.status         (status)
	);

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [frs_pkg::VALUE_WIDTH_DEF-1:0] val_t;

	typedef struct {
		val_t             num;
		val_t             den;
		frs_pkg::status_t st;
	} sum_word_t;

	typedef enum int unsigned {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_BEAT
	} rx_mode_t;

	localparam val_t MOST_NEG = 32'sh8000_0000;
	localparam val_t MOST_POS = 32'sh7fff_ffff;
	localparam int HOLD_CYCLES = 4000;
	localparam longint CYCLE_LIMIT = 10_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	val_t numerator = '0;
	val_t denominator = '0;
	logic last_item = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	val_t sum_numerator;
	val_t sum_denominator;
	logic [1:0] status;

	// Running sum as the block should hold it.
	val_t run_num = '0;
	val_t run_den = 1;
	bit in_set = 1'b0;
	bit set_wrapped = 1'b0;

	sum_word_t pending_sums[$];
	int fail_count = 0;
	longint cycles = 0;
	bit sender_idles = 1'b1;
	int burst_left = 0;
	bit hold_req = 1'b0;

	fraction_sum_reduce i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.numerator(numerator),
		.denominator(denominator),
		.last_item(last_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sum_numerator(sum_numerator),
		.sum_denominator(sum_denominator),
		.status(status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic val_t mul_wrap(input val_t a, input val_t b, inout logic ovf);
		longint p;
		p = longint'(a) * longint'(b);
		if (p != longint'(val_t'(p)))
			ovf = 1'b1;
		return val_t'(p);
	endfunction

	function automatic val_t add_wrap(input val_t a, input val_t b, inout logic ovf);
		longint s;
		s = longint'(a) + longint'(b);
		if (s != longint'(val_t'(s)))
			ovf = 1'b1;
		return val_t'(s);
	endfunction

	// Remainder and quotient truncate toward zero; the quotient wraps, so the
	// most negative value over minus one comes back as itself.
	function automatic val_t trunc_rem(input val_t a, input val_t b);
		return val_t'(longint'(a) % longint'(b));
	endfunction

	function automatic val_t trunc_quot(input val_t a, input val_t b);
		return val_t'(longint'(a) / longint'(b));
	endfunction

	// Euclid with a signed compare. A step that leaves its operand unchanged
	// can never finish, so the loop gives up and reports it.
	function automatic val_t signed_gcd(input val_t a0, input val_t b0, output logic stuck);
		val_t a;
		val_t b;
		val_t r;
		a = a0;
		b = b0;
		stuck = 1'b0;
		while (a != 0 && b != 0 && !stuck) begin
			if (b < a) begin
				r = trunc_rem(a, b);
				if (r == a)
					stuck = 1'b1;
				else
					a = r;
			end else begin
				r = trunc_rem(b, a);
				if (r == b)
					stuck = 1'b1;
				else
					b = r;
			end
		end
		return a + b;
	endfunction

	function automatic void fold_fraction(input val_t n, input val_t d, input bit lst);
		logic wrapped;
		logic stuck;
		val_t p1;
		val_t p2;
		val_t g;
		sum_word_t res;
		if (!in_set) begin
			run_num = n;
			run_den = d;
			set_wrapped = 1'b0;
			in_set = 1'b1;
		end else begin
			wrapped = 1'b0;
			p1 = mul_wrap(run_num, d, wrapped);
			p2 = mul_wrap(run_den, n, wrapped);
			run_num = add_wrap(p1, p2, wrapped);
			run_den = mul_wrap(run_den, d, wrapped);
			if (wrapped)
				set_wrapped = 1'b1;
		end
		if (lst) begin
			g = signed_gcd(run_num, run_den, stuck);
			res.st = set_wrapped ? frs_pkg::STAT_WRAP : frs_pkg::STAT_OK;
			if (g == 0 || stuck) begin
				res.st = frs_pkg::STAT_NO_REDUCE;
				res.num = run_num;
				res.den = run_den;
			end else begin
				res.num = trunc_quot(run_num, g);
				res.den = trunc_quot(run_den, g);
			end
			pending_sums.push_back(res);
			in_set = 1'b0;
			set_wrapped = 1'b0;
		end
	endfunction

	function automatic void compare_field(input string field, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endfunction

	// Value classes: small, medium, full range, and corner values.
	function automatic val_t pick_value(input int unsigned cls);
		case (cls)
			0: return val_t'(int'($urandom_range(0, 40)) - 20);
			1: return val_t'(int'($urandom_range(0, 6000)) - 3000);
			2: return val_t'($urandom());
			default: begin
				case ($urandom_range(0, 5))
					0: return 0;
					1: return 1;
					2: return -1;
					3: return MOST_NEG;
					4: return MOST_POS;
					default: return val_t'(32'sd1 << $urandom_range(0, 31));
				endcase
			end
		endcase
	endfunction

	function automatic int unsigned pick_class();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return 0;
		else if (r < 70)
			return 1;
		else if (r < 90)
			return 2;
		return 3;
	endfunction

	task automatic send_word(input val_t n, input val_t d, input bit lst);
		if (sender_idles && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		numerator <= n;
		denominator <= d;
		last_item <= lst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		fold_fraction(n, d, lst);
	endtask

	task automatic wait_for_sums();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_sums.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_word(0, 0, 1);
		send_word(0, 5, 1);
		send_word(6, 4, 1);
		send_word(-6, -6, 1);
		send_word(12, -3, 1);
		send_word(5, -3, 1);
		send_word(MOST_NEG, 1, 1);
		send_word(MOST_NEG, -1, 1);
		send_word(MOST_NEG, MOST_NEG, 1);
		send_word(MOST_POS, MOST_POS, 1);
		send_word(1, 0, 1);
		send_word(-1, MOST_NEG, 1);
		send_word(1, 2, 0);
		send_word(1, 3, 1);
		send_word(MOST_POS, 1, 0);
		send_word(MOST_POS, 1, 1);
		// Both products wrap to zero, so the wrap and the zero sum meet.
		send_word(65536, 65536, 0);
		send_word(0, 65536, 1);
		send_word(1, 2, 0);
		send_word(3, 0, 0);
		send_word(1, 5, 1);
	endtask

	// The receiver holds off for a long time while single-word sets keep
	// coming, so the output register fills and the input has to stall.
	task automatic test_backpressure();
		val_t d;
		sender_idles = 1'b0;
		hold_req = 1'b1;
		repeat (24) begin
			d = pick_value(0);
			if (d == 0)
				d = 7;
			send_word(pick_value(0), d, 1);
		end
		sender_idles = 1'b1;
		wait_for_sums();
	endtask

	task automatic test_random_sets(input int word_goal);
		int sent;
		int len;
		int unsigned cls;
		val_t n;
		val_t d;
		sent = 0;
		while (sent < word_goal) begin
			if ($urandom_range(0, 9) == 0)
				sender_idles = !sender_idles;
			cls = pick_class();
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 6);
			for (int i = 0; i < len; i++) begin
				n = pick_value(($urandom_range(0, 7) == 0) ? pick_class() : cls);
				d = pick_value(($urandom_range(0, 7) == 0) ? pick_class() : cls);
				// Mostly positive denominators, so Euclid runs long.
				if ($urandom_range(0, 4) != 0 && d < 0)
					d = -d;
				send_word(n, d, i == len - 1);
				sent++;
			end
		end
		sender_idles = 1'b1;
	endtask

	task automatic test_drain_pause();
		repeat (4) begin
			repeat ($urandom_range(2, 4)) begin
				send_word(pick_value(1), pick_value(1), 0);
				send_word(pick_value(0), pick_value(1), 1);
			end
			wait_for_sums();
		end
	endtask

	initial begin : rx_pacing
		rx_mode_t mode;
		int unsigned phase;
		mode = RX_OPEN;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			if (phase == 0)
				mode = rx_mode_t'($urandom_range(0, 3));
			phase = (phase + 1) % 300;
			case (mode)
				RX_OPEN: out_stall <= 1'b0;
				RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (phase % 7) < 3;
			endcase
		end
	end

	always @(posedge clk) begin : check_sums
		sum_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_sums.size() == 0) begin
				fail_count++;
				$display("%0t: result word with none expected: expected nothing, got %0d/%0d status %0d",
					$time, sum_numerator, sum_denominator, status);
			end else begin
				want = pending_sums.pop_front();
				compare_field("sum_numerator", want.num, sum_numerator);
				compare_field("sum_denominator", want.den, sum_denominator);
				compare_field("status", {1'b0, want.st}, {1'b0, status});
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		wait_for_sums();
		test_backpressure();
		test_random_sets(1300);
		test_drain_pause();
		wait_for_sums();
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/frs_pkg.sv
hw/rtl/frs_mul.sv
hw/rtl/frs_div.sv
hw/rtl/frs_datapath.sv
hw/rtl/frs_ctrl.sv
hw/rtl/fraction_sum_reduce.sv
tb/sv/tb_top.sv
